>>> hdl/rs_cenc_pkg.sv
// Shared types and constants for the rate 1/6, K=15 convolutional encoder.
// Holds the configuration register map, its reset values and the config bundle.
// No dependencies.
package rs_cenc_pkg;

    localparam int NUM_POLYS = 6;
    localparam int SREG_W    = 15;
    localparam int CHUNK_W   = 13;
    localparam int CFG_W     = 15;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POLY_A    = 3'd0,
        CFG_POLY_B    = 3'd1,
        CFG_POLY_C    = 3'd2,
        CFG_POLY_D    = 3'd3,
        CFG_POLY_E    = 3'd4,
        CFG_POLY_F    = 3'd5,
        CFG_CHUNK_LEN = 3'd6
    } t_cfg_idx;

    typedef logic [NUM_POLYS-1:0][SREG_W-1:0] t_poly_arr;

    typedef struct packed {
        t_poly_arr            polys;
        logic [CHUNK_W-1:0]   chunk_len;
    } t_cfg;

    localparam t_poly_arr POLY_RESET = {
        15'd26975, 15'd32439, 15'd30451, 15'd23879, 15'd20133, 15'd17817
    };
    localparam logic [CHUNK_W-1:0] CHUNK_LEN_RESET = 13'd1024;

endpackage

>>> hdl/rs_cenc_cfg.sv
// Configuration register file: six generator polynomials and the chunk length.
// Plain write port, no read-back. Depends on rs_cenc_pkg.
module rs_cenc_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [rs_cenc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [rs_cenc_pkg::CFG_W-1:0]       i_cfg_data,
    output rs_cenc_pkg::t_cfg                   o_cfg
);
    import rs_cenc_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.polys     <= POLY_RESET;
            r_cfg.chunk_len <= CHUNK_LEN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_POLY_A, CFG_POLY_B, CFG_POLY_C,
                CFG_POLY_D, CFG_POLY_E, CFG_POLY_F: begin
                    r_cfg.polys[i_cfg_idx] <= i_cfg_data[SREG_W-1:0];
                end
                CFG_CHUNK_LEN: begin
                    r_cfg.chunk_len <= i_cfg_data[CHUNK_W-1:0];
                end
                default: begin
                    // unmapped index: drop the write
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> hdl/rs_cenc_parity.sv
// Code bit generator: parity of the encoder register masked by each polynomial.
// Purely combinational. Depends on rs_cenc_pkg.
module rs_cenc_parity (
    input  logic [rs_cenc_pkg::SREG_W-1:0]      i_sreg,
    input  rs_cenc_pkg::t_poly_arr              i_polys,
    output logic [rs_cenc_pkg::NUM_POLYS-1:0]   o_code
);
    import rs_cenc_pkg::*;

    always_comb begin
        for (int k = 0; k < NUM_POLYS; k++) begin
            o_code[k] = ^(i_sreg & i_polys[k]);
        end
    end

endmodule

>>> hdl/rate_sixth_conv_encoder_zero_tail.sv
// Rate 1/6 convolutional encoder, K=15, with zero-tail termination per chunk.
// Top level: handshake control, encoder state, tail sequencer, result register.
// Depends on rs_cenc_pkg, rs_cenc_cfg and rs_cenc_parity.
//
// Usage:
//   Input request channel (i_in_valid / o_in_ready) carries one info bit.
//   Result channel (o_out_valid / i_out_ready) carries six code bits plus
//   is_tail, run_last and chunk_end flags.
//   Config writes (i_cfg_we, i_cfg_idx, i_cfg_data) take effect on the next
//   clock. Issue them only while the block is idle; it does not enforce this.
// Timing:
//   A bit accepted at edge N has its result valid after edge N. One bit is
//   taken per cycle while no tail runs and the result slot is free. The bit
//   that closes a chunk is followed by TAIL_LEN tail results from the tail
//   counter, one per cycle unless the output stalls; input waits meanwhile, so
//   L bits give L + TAIL_LEN results. A single result register sets the rate.
// Reset:
//   Synchronous, active low: encoder register, chunk count and tail counter
//   clear, config registers return to their defaults, the result slot empties.
// Stall:
//   While i_out_ready is low and a result is held, no bit is taken and the
//   tail sequence pauses; both resume as soon as the result is taken.
module rate_sixth_conv_encoder_zero_tail #(
    parameter int MAX_CHUNK = 4096,
    parameter int TAIL_LEN  = 14
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [rs_cenc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [rs_cenc_pkg::CFG_W-1:0]       i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_info_bit,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [rs_cenc_pkg::NUM_POLYS-1:0]   o_code_bits,
    output logic                                o_is_tail,
    output logic                                o_run_last,
    output logic                                o_chunk_end
);
    import rs_cenc_pkg::*;

    localparam int CNT_W  = $clog2(MAX_CHUNK + 1);
    localparam int CMP_W  = (CNT_W > CHUNK_W) ? CNT_W : CHUNK_W;
    localparam int TAIL_W = $clog2(TAIL_LEN + 1);

    t_cfg                   cfg;
    logic [SREG_W-1:0]      r_sreg, n_sreg;
    logic [CNT_W-1:0]       r_count;
    logic [TAIL_W-1:0]      r_tail_cnt;
    logic                   r_out_valid;
    logic [NUM_POLYS-1:0]   r_code, n_code;
    logic                   r_is_tail, r_run_last, r_chunk_end;

    logic                   out_free;
    logic                   tail_busy;
    logic                   in_take;
    logic                   tail_step;
    logic                   tail_last;
    logic [CMP_W-1:0]       chunk_ext;
    logic [CMP_W-1:0]       eff_len;
    logic [CMP_W-1:0]       count_inc;
    logic                   close;

    rs_cenc_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    rs_cenc_parity u_parity (
        .i_sreg  (n_sreg),
        .i_polys (cfg.polys),
        .o_code  (n_code)
    );

    assign out_free   = !r_out_valid || i_out_ready;
    assign tail_busy  = (r_tail_cnt != '0);
    assign o_in_ready = !tail_busy && out_free;
    assign in_take    = i_in_valid && o_in_ready;
    assign tail_step  = tail_busy && out_free;
    assign tail_last  = (r_tail_cnt == TAIL_W'(1));

    // Tail steps shift in zeros; info requests shift in the bit.
    assign n_sreg = {r_sreg[SREG_W-2:0], in_take & i_info_bit};

    // Clamp chunk length to [1, MAX_CHUNK].
    always_comb begin
        chunk_ext = CMP_W'(cfg.chunk_len);
        if (chunk_ext == '0) begin
            eff_len = CMP_W'(1);
        end else if (chunk_ext > CMP_W'(MAX_CHUNK)) begin
            eff_len = CMP_W'(MAX_CHUNK);
        end else begin
            eff_len = chunk_ext;
        end
        count_inc = CMP_W'(r_count) + CMP_W'(1);
        close     = (count_inc >= eff_len);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sreg      <= '0;
            r_count     <= '0;
            r_tail_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take || tail_step) begin
                r_sreg      <= n_sreg;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (in_take) begin
                if (close) begin
                    r_count    <= '0;
                    r_tail_cnt <= TAIL_W'(TAIL_LEN);
                end else begin
                    r_count <= count_inc[CNT_W-1:0];
                end
            end else if (tail_step) begin
                r_tail_cnt <= r_tail_cnt - TAIL_W'(1);
            end
        end
    end

    // Result payload: no reset needed.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_code      <= n_code;
            r_is_tail   <= 1'b0;
            r_run_last  <= !close;
            r_chunk_end <= 1'b0;
        end else if (tail_step) begin
            r_code      <= n_code;
            r_is_tail   <= 1'b1;
            r_run_last  <= tail_last;
            r_chunk_end <= tail_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_code_bits = r_code;
    assign o_is_tail   = r_is_tail;
    assign o_run_last  = r_run_last;
    assign o_chunk_end = r_chunk_end;

`ifndef SYNTHESIS
    a_chunk_end_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_chunk_end) |-> (o_is_tail && o_run_last))
        else $error("chunk_end without tail/run_last");

    a_tail_follows_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_is_tail && !o_run_last)
        |=> (r_tail_cnt == TAIL_W'(TAIL_LEN - 1)))
        else $error("tail did not start after closing bit");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (CMP_W'(r_count) < CMP_W'(MAX_CHUNK)))
        else $error("chunk count out of range");

    a_no_input_in_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (tail_busy && !$past(close && in_take)) |-> (r_count == '0))
        else $error("chunk count not cleared during tail");
`endif

endmodule
